// ===== src/mtfp_pkg.sv =====
`default_nettype none
package mtfp_pkg;

  // Frame and virtual space geometry.
  localparam int MAX_DIMENSION  = 8192;
  localparam int FADE_LEVELS    = 33;
  localparam int VIRTUAL_WIDTH  = 640;
  localparam int VIRTUAL_HEIGHT = 480;
  localparam int FRAC_BITS      = 16;

  localparam int COORD_W = $clog2(MAX_DIMENSION);      // pixel_x, pixel_y
  localparam int SIZE_W  = $clog2(MAX_DIMENSION) + 1;  // frame_width, frame_height
  localparam int SCALE_W = 26;                         // 16.16 scale, masked to 26 bits
  localparam int BYTE_W  = 8;

  // Only scale bits below FRAC_BITS + BYTE_W reach the kept product bits.
  localparam int SCALE_USED_W = FRAC_BITS + BYTE_W;
  localparam int PROD_W       = COORD_W + SCALE_USED_W;

  // Tables. The fade level saturates at a fixed row, whatever the table depth.
  localparam int TEX_DEPTH    = 65536;
  localparam int TEX_ADDR_W   = $clog2(TEX_DEPTH);
  localparam int FADE_DEPTH   = FADE_LEVELS * 256;
  localparam int FADE_ADDR_W  = $clog2(FADE_DEPTH);
  localparam int FADE_CAP     = 32;
  localparam int LEVEL_W      = $clog2(FADE_LEVELS);
  localparam int TABLE_ADDR_W = 16;

  // Scale divider.
  localparam int DIV_CNT_W = $clog2(SCALE_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SCALE_W - 1);
  localparam logic [SCALE_W-1:0] DIVIDEND_H = SCALE_W'(VIRTUAL_WIDTH * 65536);
  localparam logic [SCALE_W-1:0] DIVIDEND_V = SCALE_W'(VIRTUAL_HEIGHT * 65536);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  typedef enum logic [1:0] {
    REQ_PIXEL   = 2'd0,
    REQ_TEXTURE = 2'd1,
    REQ_FADE    = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_PRIMARY_X    = 3'd2,
    REG_PRIMARY_Y    = 3'd3,
    REG_SECONDARY_X  = 3'd4,
    REG_SECONDARY_Y  = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  rem;
    logic [SCALE_W-1:0] quo;
  } div_state_t;

  // One restoring division step: the dividend shifts out of quo while
  // quotient bits shift in behind it.
  function automatic div_state_t div_step(div_state_t s, logic [SIZE_W-1:0] d);
    logic [SIZE_W:0] trial;
    div_state_t      r;
    trial = {s.rem, s.quo[SCALE_W-1]};
    r.quo = {s.quo[SCALE_W-2:0], 1'b0};
    r.rem = trial[SIZE_W-1:0];
    if (trial >= {1'b0, d}) begin
      r.rem    = SIZE_W'(trial - {1'b0, d});
      r.quo[0] = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/mist_texture_fade_pixel.sv =====
`default_nettype none
// A pixel request is registered in stage 1 and moves through the five-stage pipeline to
// out_pixel. Throughput: one request per cycle while result_ready holds and no divider runs.
// A write to frame_width or frame_height runs a serial divider, one quotient bit a cycle;
// no request is taken while it runs.
// Reset (rst, synchronous, active high) clears the pipeline valid bits and dividers and
// loads 640, 480, 0, 0, 0, 0 and unit scales. Texture and fade tables are not cleared.
module mist_texture_fade_pixel
  import mtfp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  // Request channel.
  input  wire logic                    item_valid,
  output logic                         item_ready,
  input  wire logic [1:0]              req_type,
  input  wire logic [COORD_W-1:0]      pixel_x,
  input  wire logic [COORD_W-1:0]      pixel_y,
  input  wire logic [BYTE_W-1:0]       source_pixel,
  input  wire logic [TABLE_ADDR_W-1:0] table_addr,
  input  wire logic [BYTE_W-1:0]       table_data,
  // Result channel.
  output logic                         result_valid,
  input  wire logic                    result_ready,
  output logic      [BYTE_W-1:0]       out_pixel,
  // Configuration port.
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [APB_ADDR_W-1:0]   paddr,
  input  wire logic [APB_DATA_W-1:0]   pwdata,
  output logic      [APB_DATA_W-1:0]   prdata,
  output logic                         pready
);

  // ---------------------------------------------------------------------------------------
  // Configuration registers. The register index sits in the word address bits.
  // ---------------------------------------------------------------------------------------
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic [BYTE_W-1:0] primary_x;
  logic [BYTE_W-1:0] primary_y;
  logic [BYTE_W-1:0] secondary_x;
  logic [BYTE_W-1:0] secondary_y;
  logic [2:0]        reg_sel;
  logic              cfg_write;
  logic [SIZE_W-1:0] size_wdata;
  logic [SIZE_W-1:0] divisor_wdata;

  assign pready        = 1'b1;
  assign reg_sel       = paddr[4:2];
  assign cfg_write     = psel && penable && pwrite && pready;
  assign size_wdata    = pwdata[SIZE_W-1:0];
  // A frame size of zero divides as if it were one.
  assign divisor_wdata = (size_wdata == '0) ? SIZE_W'(1) : size_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= SIZE_W'(VIRTUAL_WIDTH);
      frame_height <= SIZE_W'(VIRTUAL_HEIGHT);
      primary_x    <= '0;
      primary_y    <= '0;
      secondary_x  <= '0;
      secondary_y  <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_FRAME_WIDTH:  frame_width  <= size_wdata;
        REG_FRAME_HEIGHT: frame_height <= size_wdata;
        REG_PRIMARY_X:    primary_x    <= pwdata[BYTE_W-1:0];
        REG_PRIMARY_Y:    primary_y    <= pwdata[BYTE_W-1:0];
        REG_SECONDARY_X:  secondary_x  <= pwdata[BYTE_W-1:0];
        REG_SECONDARY_Y:  secondary_y  <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
      REG_PRIMARY_X:    prdata = APB_DATA_W'(primary_x);
      REG_PRIMARY_Y:    prdata = APB_DATA_W'(primary_y);
      REG_SECONDARY_X:  prdata = APB_DATA_W'(secondary_x);
      REG_SECONDARY_Y:  prdata = APB_DATA_W'(secondary_y);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Scale dividers. Each computes (virtual size << 16) / frame size by restoring division,
  // one quotient bit per cycle, and loads its scale register on the last step.
  // ---------------------------------------------------------------------------------------
  logic [SCALE_W-1:0]   scale_h;
  logic [SCALE_W-1:0]   scale_v;
  logic                 hdiv_busy;
  logic                 vdiv_busy;
  logic [DIV_CNT_W-1:0] hdiv_cnt;
  logic [DIV_CNT_W-1:0] vdiv_cnt;
  logic [SIZE_W-1:0]    hdiv_d;
  logic [SIZE_W-1:0]    vdiv_d;
  div_state_t           hdiv;
  div_state_t           vdiv;
  div_state_t           hdiv_next;
  div_state_t           vdiv_next;

  assign hdiv_next = div_step(hdiv, hdiv_d);
  assign vdiv_next = div_step(vdiv, vdiv_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      hdiv_busy <= 1'b0;
      hdiv_cnt  <= '0;
      scale_h   <= SCALE_RESET;
    end else if (cfg_write && reg_sel == REG_FRAME_WIDTH) begin
      hdiv_busy <= 1'b1;
      hdiv_cnt  <= '0;
      hdiv_d    <= divisor_wdata;
      hdiv.rem  <= '0;
      hdiv.quo  <= DIVIDEND_H;
    end else if (hdiv_busy) begin
      hdiv     <= hdiv_next;
      hdiv_cnt <= hdiv_cnt + 1'b1;
      if (hdiv_cnt == DIV_LAST) begin
        hdiv_busy <= 1'b0;
        scale_h   <= hdiv_next.quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vdiv_busy <= 1'b0;
      vdiv_cnt  <= '0;
      scale_v   <= SCALE_RESET;
    end else if (cfg_write && reg_sel == REG_FRAME_HEIGHT) begin
      vdiv_busy <= 1'b1;
      vdiv_cnt  <= '0;
      vdiv_d    <= divisor_wdata;
      vdiv.rem  <= '0;
      vdiv.quo  <= DIVIDEND_V;
    end else if (vdiv_busy) begin
      vdiv     <= vdiv_next;
      vdiv_cnt <= vdiv_cnt + 1'b1;
      if (vdiv_cnt == DIV_LAST) begin
        vdiv_busy <= 1'b0;
        scale_v   <= vdiv_next.quo;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Pipeline control. Each stage loads when it is empty or its successor loads, so bubbles
  // close up and a stalled result holds everything behind it without losing a request.
  // Table writes ride down the pipeline and hit each table in the same stage that reads
  // it, which keeps reads and writes in request order.
  // ---------------------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;
  logic [1:0] s4_kind;

  assign en5 = !v5 || result_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign item_ready   = en1 && !hdiv_busy && !vdiv_busy;
  assign result_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= item_valid && item_ready;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      // Only pixel requests leave the last stage as results.
      if (en5) v5 <= v4 && s4_kind == REQ_PIXEL;
    end
  end

  // Stage 1: request register.
  logic [1:0]              s1_kind;
  logic [COORD_W-1:0]      s1_x;
  logic [COORD_W-1:0]      s1_y;
  logic [BYTE_W-1:0]       s1_src;
  logic [TABLE_ADDR_W-1:0] s1_addr;
  logic [BYTE_W-1:0]       s1_data;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_kind <= req_type;
      s1_x    <= pixel_x;
      s1_y    <= pixel_y;
      s1_src  <= source_pixel;
      s1_addr <= table_addr;
      s1_data <= table_data;
    end
  end

  // Stage 2: virtual coordinates. Only product bits 23:16 survive the mod-256 wrap, so
  // only the low 24 bits of each scale take part.
  logic [PROD_W-1:0]       prod_h;
  logic [PROD_W-1:0]       prod_v;
  logic [1:0]              s2_kind;
  logic [BYTE_W-1:0]       s2_vx;
  logic [BYTE_W-1:0]       s2_vy;
  logic [BYTE_W-1:0]       s2_src;
  logic [TABLE_ADDR_W-1:0] s2_addr;
  logic [BYTE_W-1:0]       s2_data;

  assign prod_h = PROD_W'(s1_x) * PROD_W'(scale_h[SCALE_USED_W-1:0]);
  assign prod_v = PROD_W'(s1_y) * PROD_W'(scale_v[SCALE_USED_W-1:0]);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_kind <= s1_kind;
      s2_vx   <= prod_h[FRAC_BITS +: BYTE_W];
      s2_vy   <= prod_v[FRAC_BITS +: BYTE_W];
      s2_src  <= s1_src;
      s2_addr <= s1_addr;
      s2_data <= s1_data;
    end
  end

  // Stage 3: texture reads. The texture is kept twice so the primary and the mirrored,
  // transposed sample are read in the same cycle; both copies take every write.
  logic [BYTE_W-1:0]       row_a, col_a, row_b, col_b;
  logic [TEX_ADDR_W-1:0]   tex_raddr_a;
  logic [TEX_ADDR_W-1:0]   tex_raddr_b;
  logic                    tex_we;
  logic [BYTE_W-1:0]       tex_a;
  logic [BYTE_W-1:0]       tex_b;
  logic [1:0]              s3_kind;
  logic [BYTE_W-1:0]       s3_src;
  logic [TABLE_ADDR_W-1:0] s3_addr;
  logic [BYTE_W-1:0]       s3_data;

  assign row_a       = primary_y + s2_vy;
  assign col_a       = primary_x + s2_vx;
  assign row_b       = secondary_y - s2_vx;
  assign col_b       = secondary_x - s2_vy;
  assign tex_raddr_a = {row_a, col_a};
  assign tex_raddr_b = {row_b, col_b};
  assign tex_we      = en3 && v2 && s2_kind == REQ_TEXTURE;

  mtfp_ram #(.WIDTH(BYTE_W), .DEPTH(TEX_DEPTH)) u_tex_a (
    .clk   (clk),
    .we    (tex_we),
    .waddr (s2_addr[TEX_ADDR_W-1:0]),
    .wdata (s2_data),
    .re    (en3),
    .raddr (tex_raddr_a),
    .rdata (tex_a)
  );

  mtfp_ram #(.WIDTH(BYTE_W), .DEPTH(TEX_DEPTH)) u_tex_b (
    .clk   (clk),
    .we    (tex_we),
    .waddr (s2_addr[TEX_ADDR_W-1:0]),
    .wdata (s2_data),
    .re    (en3),
    .raddr (tex_raddr_b),
    .rdata (tex_b)
  );

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_kind <= s2_kind;
      s3_src  <= s2_src;
      s3_addr <= s2_addr;
      s3_data <= s2_data;
    end
  end

  // Stage 4: fade level, the sum of both samples divided by eight and capped.
  logic [BYTE_W:0]         tex_sum;
  logic [LEVEL_W-1:0]      level_raw;
  logic [LEVEL_W-1:0]      level;
  logic [FADE_ADDR_W-1:0]  s4_fade_idx;
  logic [TABLE_ADDR_W-1:0] s4_addr;
  logic [BYTE_W-1:0]       s4_data;

  assign tex_sum   = {1'b0, tex_a} + {1'b0, tex_b};
  assign level_raw = LEVEL_W'(tex_sum >> 3);
  assign level     = (level_raw > LEVEL_W'(FADE_CAP)) ? LEVEL_W'(FADE_CAP) : level_raw;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_kind     <= s3_kind;
      s4_fade_idx <= FADE_ADDR_W'({level, s3_src});
      s4_addr     <= s3_addr;
      s4_data     <= s3_data;
    end
  end

  // Stage 5: fade table read; its registered output is the result. Writes beyond the
  // table are dropped.
  logic fade_we;

  assign fade_we = en5 && v4 && s4_kind == REQ_FADE &&
                   s4_addr < TABLE_ADDR_W'(FADE_DEPTH);

  mtfp_ram #(.WIDTH(BYTE_W), .DEPTH(FADE_DEPTH)) u_fade (
    .clk   (clk),
    .we    (fade_we),
    .waddr (s4_addr[FADE_ADDR_W-1:0]),
    .wdata (s4_data),
    .re    (en5),
    .raddr (s4_fade_idx),
    .rdata (out_pixel)
  );

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------
  // No request may enter while a scale is being recomputed.
  a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (rst)
    (hdiv_busy || vdiv_busy) |-> !item_ready)
    else $error("request taken while a scale divider is busy");

  // Each divider finishes after exactly its last step.
  a_hdiv_finishes: assert property (@(posedge clk) disable iff (rst)
    (hdiv_busy && hdiv_cnt == DIV_LAST && !cfg_write) |=> !hdiv_busy)
    else $error("horizontal divider did not finish after its last step");

  a_vdiv_finishes: assert property (@(posedge clk) disable iff (rst)
    (vdiv_busy && vdiv_cnt == DIV_LAST && !cfg_write) |=> !vdiv_busy)
    else $error("vertical divider did not finish after its last step");

  // A result held at the output keeps the fade table read port frozen.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (v5 && !result_ready) |-> (!en5 && !fade_we))
    else $error("pipeline moved under a stalled result");

endmodule
`default_nettype wire

// ===== src/mtfp_ram.sv =====
`default_nettype none
module mtfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
// The request channel carries pixel, texture write and fade write requests. The testbench
// keeps its own copy of both tables, the six registers and the two scales, and works out
// the faded pixel for every accepted pixel request. A pixel request is only sent once
// every table entry that it reads has been written, so the tables never need a reset.
module tb;
  import mtfp_pkg::*;

  // The block ignores this request kind and these register indexes.
  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam int UNMAPPED_REG_A = 6;
  localparam int UNMAPPED_REG_B = 7;

  // SETTLE_CYCLES covers the pipeline draining after its last request, DIVIDE_CYCLES the
  // divider that a size write keeps busy. Both waits are rounded up.
  localparam int SETTLE_CYCLES = 8;
  localparam int DIVIDE_CYCLES = 32;
  localparam int DRAIN_LIMIT   = 5000;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    item_valid;
  logic                    item_ready;
  logic [1:0]              req_type;
  logic [COORD_W-1:0]      pixel_x;
  logic [COORD_W-1:0]      pixel_y;
  logic [BYTE_W-1:0]       source_pixel;
  logic [TABLE_ADDR_W-1:0] table_addr;
  logic [BYTE_W-1:0]       table_data;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  logic [BYTE_W-1:0]       out_pixel;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [APB_ADDR_W-1:0]   paddr;
  logic [APB_DATA_W-1:0]   pwdata;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  mist_texture_fade_pixel u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .req_type     (req_type),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .source_pixel (source_pixel),
    .table_addr   (table_addr),
    .table_data   (table_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_pixel    (out_pixel),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk = ~clk;

  // Shadow of the block: both tables with a written flag per entry, the registers and
  // the scales derived from the frame size.
  logic [BYTE_W-1:0]  texture_copy [TEX_DEPTH];
  logic [BYTE_W-1:0]  fade_copy    [FADE_DEPTH];
  bit                 texture_known[TEX_DEPTH];
  bit                 fade_known   [FADE_DEPTH];
  logic [SIZE_W-1:0]  width_reg;
  logic [SIZE_W-1:0]  height_reg;
  logic [BYTE_W-1:0]  prim_x_reg;
  logic [BYTE_W-1:0]  prim_y_reg;
  logic [BYTE_W-1:0]  sec_x_reg;
  logic [BYTE_W-1:0]  sec_y_reg;
  logic [SCALE_W-1:0] h_scale;
  logic [SCALE_W-1:0] v_scale;

  // Faded pixels still owed by the block, oldest first.
  logic [BYTE_W-1:0]  expected_pixels[$];
  logic [BYTE_W-1:0]  due_pixel;
  int                 errors = 0;
  int                 requests_sent = 0;
  int                 burst_left = 0;
  logic [15:0]        last_primary = '0;

  // 16.16 scale from a virtual extent and a frame size; a size of zero counts as one.
  function automatic logic [SCALE_W-1:0] scale_for_size(int unsigned virt,
                                                         logic [SIZE_W-1:0] size);
    longint unsigned dividend;
    longint unsigned divisor;
    dividend = 64'(virt);
    dividend = dividend << FRAC_BITS;
    divisor  = (size == 0) ? 64'd1 : 64'(size);
    return SCALE_W'(dividend / divisor);
  endfunction

  // Texture addresses of the primary sample and of the mirrored, transposed one.
  task automatic texture_taps(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              output logic [15:0] first, output logic [15:0] second);
    longint unsigned px;
    longint unsigned py;
    logic [7:0]      vx;
    logic [7:0]      vy;
    px = 64'(x);
    py = 64'(y);
    px = px * 64'(h_scale);
    py = py * 64'(v_scale);
    vx = px[23:16];
    vy = py[23:16];
    first  = {8'(prim_y_reg + vy), 8'(prim_x_reg + vx)};
    second = {8'(sec_y_reg - vx), 8'(sec_x_reg - vy)};
  endtask

  // Fade table entry for two texture bytes and a source pixel; the level saturates.
  function automatic int fade_entry(logic [15:0] first, logic [15:0] second,
                                    logic [7:0] src);
    logic [8:0] sum;
    int         level;
    sum   = {1'b0, texture_copy[first]} + {1'b0, texture_copy[second]};
    level = int'(sum >> 3);
    if (level > FADE_CAP) level = FADE_CAP;
    return level * 256 + int'(src);
  endfunction

  // Drives one request and holds it until the block takes it. The shadow state is
  // updated at the accepting edge. Requests go out in bursts; when a burst ends, valid
  // drops for a random number of cycles.
  task automatic issue_request(input logic [1:0] kind, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y, input logic [7:0] src,
                               input logic [15:0] addr, input logic [7:0] data);
    logic [15:0] first;
    logic [15:0] second;
    @(negedge clk);
    item_valid   = 1'b1;
    req_type     = kind;
    pixel_x      = x;
    pixel_y      = y;
    source_pixel = src;
    table_addr   = addr;
    table_data   = data;
    do @(posedge clk); while (!item_ready);
    requests_sent++;
    case (kind)
      REQ_TEXTURE: begin
        texture_copy[addr]  = data;
        texture_known[addr] = 1'b1;
      end
      REQ_FADE: begin
        if (int'(addr) < FADE_DEPTH) begin
          fade_copy[addr]  = data;
          fade_known[addr] = 1'b1;
        end
      end
      REQ_PIXEL: begin
        texture_taps(x, y, first, second);
        expected_pixels.push_back(fade_copy[fade_entry(first, second, src)]);
      end
      default: ;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      item_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Sends a pixel request, first loading any texture or fade entry that it would read
  // and that has not been written yet.
  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [7:0] src);
    logic [15:0] first;
    logic [15:0] second;
    int          entry;
    texture_taps(x, y, first, second);
    if (!texture_known[first])
      issue_request(REQ_TEXTURE, 13'($urandom), 13'($urandom), 8'($urandom), first,
                    8'($urandom));
    if (!texture_known[second])
      issue_request(REQ_TEXTURE, 13'($urandom), 13'($urandom), 8'($urandom), second,
                    8'($urandom));
    entry = fade_entry(first, second, src);
    if (!fade_known[entry])
      issue_request(REQ_FADE, 13'($urandom), 13'($urandom), 8'($urandom), 16'(entry),
                    8'($urandom));
    issue_request(REQ_PIXEL, x, y, src, 16'($urandom), 8'($urandom));
    last_primary = first;
  endtask

  // Lowers valid and waits until every result is in and the pipeline has drained.
  task automatic go_idle();
    if (item_valid) begin
      @(negedge clk);
      item_valid = 1'b0;
    end
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write with a setup phase and an access phase, done only while the block is idle.
  // The wait afterwards covers the scale divider.
  task automatic set_register(input int index, input logic [31:0] value);
    go_idle();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_W'(index * 4);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      REG_FRAME_WIDTH: begin
        width_reg = value[SIZE_W-1:0];
        h_scale   = scale_for_size(VIRTUAL_WIDTH, width_reg);
      end
      REG_FRAME_HEIGHT: begin
        height_reg = value[SIZE_W-1:0];
        v_scale    = scale_for_size(VIRTUAL_HEIGHT, height_reg);
      end
      REG_PRIMARY_X:   prim_x_reg = value[7:0];
      REG_PRIMARY_Y:   prim_y_reg = value[7:0];
      REG_SECONDARY_X: sec_x_reg  = value[7:0];
      REG_SECONDARY_Y: sec_y_reg  = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    repeat (DIVIDE_CYCLES) @(posedge clk);
  endtask

  // Default geometry, opposite corner pixels of the frame, both extremes of the source pixel.
  task automatic test_basic_lookup();
    issue_request(REQ_TEXTURE, '0, '0, '0, 16'h0000, 8'h00);
    issue_request(REQ_FADE, '0, '0, '0, 16'h0000, 8'h5A);
    issue_request(REQ_PIXEL, 13'd0, 13'd0, 8'h00, 16'hFFFF, 8'hFF);
    send_pixel(13'd0, 13'd0, 8'hFF);
    send_pixel(13'd639, 13'd479, 8'h80);
  endtask

  // Far corner of the coordinate range, well outside the frame. Both samples hold 255,
  // so the level is capped at the last fade row, read at its last column.
  task automatic test_fade_cap();
    issue_request(REQ_TEXTURE, '0, '0, '0, 16'hFFFF, 8'hFF);
    issue_request(REQ_TEXTURE, '0, '0, '0, 16'h0101, 8'hFF);
    issue_request(REQ_FADE, '0, '0, '0, 16'(FADE_DEPTH - 1), 8'hC3);
    issue_request(REQ_PIXEL, 13'h1FFF, 13'h1FFF, 8'hFF, 16'h0000, 8'h00);
  endtask

  // Fade writes past the table and reserved requests must leave entry zero alone;
  // the first address would alias onto it if the address were cut short.
  task automatic test_ignored_requests();
    issue_request(REQ_FADE, '0, '0, '0, 16'h4000, 8'hFF);
    issue_request(REQ_FADE, '0, '0, '0, 16'(FADE_DEPTH), 8'hFF);
    issue_request(REQ_FADE, '0, '0, '0, 16'hFFFF, 8'h00);
    issue_request(REQ_RESERVED, 13'd0, 13'd0, 8'h00, 16'h0000, 8'hFF);
    issue_request(REQ_PIXEL, 13'd0, 13'd0, 8'h00, 16'h1234, 8'h77);
  endtask

  // Writes to indexes past the register file change nothing.
  task automatic test_unknown_register();
    set_register(UNMAPPED_REG_A, $urandom);
    set_register(UNMAPPED_REG_B, $urandom);
    send_pixel(13'd320, 13'd240, 8'h3C);
    send_pixel(13'($urandom), 13'($urandom), 8'($urandom));
  endtask

  // A frame size of zero behaves as a size of one.
  task automatic test_zero_frame_size();
    set_register(REG_FRAME_WIDTH, 32'd0);
    set_register(REG_FRAME_HEIGHT, 32'd0);
    repeat (6) send_pixel(13'($urandom), 13'($urandom), 8'($urandom));
  endtask

  // One register setting, then a random mix: mostly pixel requests with the table
  // writes they need, plus stray texture writes (often onto the entry that the last
  // pixel read), fade writes in and past the table, and reserved requests. Upper bits
  // of the register data are junk that the block must drop.
  task automatic run_random_phase(input int w, input int h, input int px, input int py,
                                  input int sx, input int sy, input int count);
    int target;
    int pick;
    int span_x;
    int span_y;
    set_register(REG_FRAME_WIDTH, {18'($urandom), 14'(w)});
    set_register(REG_FRAME_HEIGHT, {18'($urandom), 14'(h)});
    set_register(REG_PRIMARY_X, {24'($urandom), 8'(px)});
    set_register(REG_PRIMARY_Y, {24'($urandom), 8'(py)});
    set_register(REG_SECONDARY_X, {24'($urandom), 8'(sx)});
    set_register(REG_SECONDARY_Y, {24'($urandom), 8'(sy)});
    span_x = (w == 0) ? 1 : ((w > MAX_DIMENSION) ? MAX_DIMENSION : w);
    span_y = (h == 0) ? 1 : ((h > MAX_DIMENSION) ? MAX_DIMENSION : h);
    target = requests_sent + count;
    while (requests_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        if ($urandom_range(0, 1) == 0)
          send_pixel(13'($urandom_range(0, span_x - 1)), 13'($urandom_range(0, span_y - 1)),
                     8'($urandom));
        else
          send_pixel(13'($urandom), 13'($urandom), 8'($urandom));
      end else if (pick < 82) begin
        issue_request(REQ_TEXTURE, 13'($urandom), 13'($urandom), 8'($urandom),
                      (pick < 77) ? last_primary : 16'($urandom), 8'($urandom));
      end else if (pick < 92) begin
        issue_request(REQ_FADE, 13'($urandom), 13'($urandom), 8'($urandom),
                      ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, FADE_DEPTH - 1))
                                                  : 16'($urandom), 8'($urandom));
      end else begin
        issue_request(REQ_RESERVED, 13'($urandom), 13'($urandom), 8'($urandom),
                      ($urandom_range(0, 1) == 0) ? last_primary : 16'($urandom),
                      8'($urandom));
      end
    end
  endtask

  // Result checker: every accepted result is compared with the oldest faded pixel owed.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: out_pixel %02h arrived with no request owing one", $time, out_pixel);
        errors++;
      end else begin
        due_pixel = expected_pixels.pop_front();
        if (out_pixel !== due_pixel) begin
          $display("%0t: out_pixel expected %02h actual %02h", $time, due_pixel, out_pixel);
          errors++;
        end
      end
    end
  end

  // The result side takes turns between always ready, coin-flip stalls, mostly stalled,
  // and a regular stall before each acceptance.
  int ready_mode  = 0;
  int ready_left  = 0;
  int ready_phase = 0;

  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(10, 120);
    end
    ready_left--;
    ready_phase++;
    case (ready_mode)
      0:       result_ready <= 1'b1;
      1:       result_ready <= 1'($urandom_range(0, 1));
      2:       result_ready <= ($urandom_range(0, 3) == 0);
      default: result_ready <= (ready_phase % 13 == 0);
    endcase
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int waited;
    rst          = 1'b1;
    item_valid   = 1'b0;
    req_type     = REQ_PIXEL;
    pixel_x      = '0;
    pixel_y      = '0;
    source_pixel = '0;
    table_addr   = '0;
    table_data   = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    width_reg    = SIZE_W'(VIRTUAL_WIDTH);
    height_reg   = SIZE_W'(VIRTUAL_HEIGHT);
    prim_x_reg   = '0;
    prim_y_reg   = '0;
    sec_x_reg    = '0;
    sec_y_reg    = '0;
    h_scale      = scale_for_size(VIRTUAL_WIDTH, width_reg);
    v_scale      = scale_for_size(VIRTUAL_HEIGHT, height_reg);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_lookup();
    test_fade_cap();
    test_ignored_requests();
    test_unknown_register();
    test_zero_frame_size();

    // Register extremes first, then two random settings.
    run_random_phase(640, 480, 0, 0, 0, 0, 200);
    run_random_phase(1, 1, 255, 255, 255, 255, 200);
    run_random_phase(8192, 8192, 0, 255, 255, 0, 200);
    run_random_phase(16383, 16383, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255), 200);
    repeat (2)
      run_random_phase($urandom_range(1, MAX_DIMENSION), $urandom_range(1, MAX_DIMENSION),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255), 230);

    // Let the last requests drain, with a bound of its own.
    if (item_valid) begin
      @(negedge clk);
      item_valid = 1'b0;
    end
    waited = 0;
    while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d faded pixels never arrived", $time, expected_pixels.size());
      errors++;
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
src/mtfp_pkg.sv
src/mtfp_ram.sv
src/mist_texture_fade_pixel.sv
tb/tb.sv
